// File: rtl/tpte_pkg.sv
// ----------------------------------------------------------------------------
// tpte_pkg: shared types and constants of the tunnel peer timer engine
// Register map, request codes, timer slots and the config/result bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tpte_pkg;

    // Field widths
    localparam int REQ_W      = 4;
    localparam int JIT_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int ATT_W      = 7;
    localparam int NUM_TIMERS = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK       = 4'd0;
    localparam logic [REQ_W-1:0] REQ_DATA_RX    = 4'd1;
    localparam logic [REQ_W-1:0] REQ_DATA_TX    = 4'd2;
    localparam logic [REQ_W-1:0] REQ_AUTH_TX    = 4'd3;
    localparam logic [REQ_W-1:0] REQ_AUTH_RX    = 4'd4;
    localparam logic [REQ_W-1:0] REQ_AUTH_TRAV  = 4'd5;
    localparam logic [REQ_W-1:0] REQ_HS_DONE    = 4'd6;
    localparam logic [REQ_W-1:0] REQ_HS_INIT    = 4'd7;
    localparam logic [REQ_W-1:0] REQ_SESSION    = 4'd8;

    // Timer slots, also the bit order of the pending mask
    localparam int T_RETX  = 0;
    localparam int T_KA    = 1;
    localparam int T_PERS  = 2;
    localparam int T_ZERO  = 3;
    localparam int T_NEWHS = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_VALID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REKEY       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPT = 3'd5;

    // Timing constants
    localparam logic [JIT_W-1:0] JITTER_MAX  = 9'd333;
    localparam logic [31:0]      MS_PER_S    = 32'd1000;
    localparam logic [31:0]      ZERO_FACTOR = 32'd3;
    localparam logic [ATT_W-1:0] ATT_MAX     = 7'd127;

    typedef struct packed {
        logic       peer_valid;
        logic       persistent_enable;
        logic [7:0] keepalive_seconds;
        logic [7:0] rekey_seconds;
        logic [9:0] reject_seconds;
        logic [5:0] max_attempts;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        peer_valid:        1'b0,
        persistent_enable: 1'b0,
        keepalive_seconds: 8'd10,
        rekey_seconds:     8'd5,
        reject_seconds:    10'd180,
        max_attempts:      6'd18
    };

    typedef struct packed {
        logic                  start_handshake;
        logic                  handshake_retry;
        logic [1:0]            keepalive_sends;
        logic                  purge_queue;
        logic                  zero_keys;
        logic [ATT_W-1:0]      attempt_count;
        logic [NUM_TIMERS-1:0] pending_mask;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/tpte_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpte_cfg_regs: configuration register file
// Decodes the register index of a write word and holds the six settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tpte_cfg_regs
    import tpte_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_PEER_VALID:  cfg_next.peer_valid        = wr_data[0];
                CFG_PERSISTENT:  cfg_next.persistent_enable = wr_data[0];
                CFG_KEEPALIVE:   cfg_next.keepalive_seconds = wr_data[7:0];
                CFG_REKEY:       cfg_next.rekey_seconds     = wr_data[7:0];
                CFG_REJECT:      cfg_next.reject_seconds    = wr_data[9:0];
                CFG_MAX_ATTEMPT: cfg_next.max_attempts      = wr_data[5:0];
                default:         cfg_next = cfg_reg;  // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/tpte_timer_core.sv
// ----------------------------------------------------------------------------
// tpte_timer_core: timer state and single-pass next-state logic
// Holds the five countdowns, pending bits, attempt counter and the
// need-another-keepalive flag; computes the result word of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module tpte_timer_core
    import tpte_pkg::*;
#(
    parameter int TIMER_WIDTH = 22
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [REQ_W-1:0] req,
    input  wire logic [JIT_W-1:0] jitter,
    input  wire cfg_t             cfg,
    output result_t               res
);

    localparam logic [32:0] TOP_LIM = (33'd1 << TIMER_WIDTH) - 33'd1;

    logic [TIMER_WIDTH-1:0] rem_reg  [NUM_TIMERS];
    logic [TIMER_WIDTH-1:0] rem_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  pend_reg, pend_next;
    logic [ATT_W-1:0]       att_reg, att_next;
    logic                   nka_reg, nka_next;

    logic [NUM_TIMERS-1:0]  fired;
    logic [JIT_W-1:0]       jit_sat;
    logic [31:0]            ka_dur, newhs_dur, retx_dur, zero_dur;

    // Zero loads as 1 ms, overlong durations clamp to the counter maximum
    function automatic logic [TIMER_WIDTH-1:0] sat_dur(input logic [31:0] d);
        if (d == 32'd0)
            return TIMER_WIDTH'(1);
        else if ({1'b0, d} > TOP_LIM)
            return TOP_LIM[TIMER_WIDTH-1:0];
        else
            return d[TIMER_WIDTH-1:0];
    endfunction

    assign jit_sat   = (jitter > JITTER_MAX) ? JITTER_MAX : jitter;
    assign ka_dur    = 32'(cfg.keepalive_seconds) * MS_PER_S;
    assign newhs_dur = (32'(cfg.keepalive_seconds) + 32'(cfg.rekey_seconds)) * MS_PER_S
                       + 32'(jit_sat);
    assign retx_dur  = 32'(cfg.rekey_seconds) * MS_PER_S + 32'(jit_sat);
    assign zero_dur  = 32'(cfg.reject_seconds) * (ZERO_FACTOR * MS_PER_S);

    always_comb
    begin
        rem_next  = rem_reg;
        pend_next = pend_reg;
        att_next  = att_reg;
        nka_next  = nka_reg;
        fired     = '0;
        res       = '0;

        unique case (req)
            REQ_TICK:
            begin
                // count everything down first
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (pend_reg[i])
                    begin
                        if (rem_reg[i] != '0)
                            rem_next[i] = rem_reg[i] - TIMER_WIDTH'(1);
                        if (rem_next[i] == '0)
                        begin
                            pend_next[i] = 1'b0;
                            fired[i]     = 1'b1;
                        end
                    end
                end
                // then handlers in fixed order
                if (fired[T_RETX])
                begin
                    if (att_reg > {1'b0, cfg.max_attempts})
                    begin
                        // give up: kill keepalive, purge, schedule key zeroing
                        rem_next[T_KA]  = '0;
                        pend_next[T_KA] = 1'b0;
                        fired[T_KA]     = 1'b0;
                        res.purge_queue = 1'b1;
                        if (!pend_next[T_ZERO] && cfg.peer_valid)
                        begin
                            rem_next[T_ZERO]  = sat_dur(zero_dur);
                            pend_next[T_ZERO] = 1'b1;
                        end
                    end
                    else
                    begin
                        if (att_reg < ATT_MAX)
                            att_next = att_reg + ATT_W'(1);
                        res.start_handshake = 1'b1;
                        res.handshake_retry = 1'b1;
                    end
                end
                if (fired[T_KA])
                begin
                    res.keepalive_sends = 2'd1;
                    if (nka_reg)
                    begin
                        nka_next = 1'b0;
                        if (cfg.peer_valid)
                        begin
                            rem_next[T_KA]  = sat_dur(ka_dur);
                            pend_next[T_KA] = 1'b1;
                        end
                    end
                end
                if (fired[T_PERS] && cfg.persistent_enable)
                    res.keepalive_sends = res.keepalive_sends + 2'd1;
                if (fired[T_ZERO])
                    res.zero_keys = 1'b1;
                if (fired[T_NEWHS])
                    res.start_handshake = 1'b1;
            end
            REQ_DATA_RX:
            begin
                if (pend_reg[T_KA])
                    nka_next = 1'b1;
                else if (cfg.peer_valid)
                begin
                    rem_next[T_KA]  = sat_dur(ka_dur);
                    pend_next[T_KA] = 1'b1;
                end
            end
            REQ_DATA_TX:
            begin
                if (!pend_reg[T_NEWHS] && cfg.peer_valid)
                begin
                    rem_next[T_NEWHS]  = sat_dur(newhs_dur);
                    pend_next[T_NEWHS] = 1'b1;
                end
            end
            REQ_AUTH_TX:
            begin
                rem_next[T_KA]  = '0;
                pend_next[T_KA] = 1'b0;
            end
            REQ_AUTH_RX:
            begin
                rem_next[T_NEWHS]  = '0;
                pend_next[T_NEWHS] = 1'b0;
            end
            REQ_AUTH_TRAV:
            begin
                if (cfg.persistent_enable && cfg.peer_valid)
                begin
                    rem_next[T_PERS]  = sat_dur(ka_dur);
                    pend_next[T_PERS] = 1'b1;
                end
            end
            REQ_HS_DONE:
            begin
                rem_next[T_RETX]  = '0;
                pend_next[T_RETX] = 1'b0;
                att_next          = '0;
            end
            REQ_HS_INIT:
            begin
                if (cfg.peer_valid)
                begin
                    rem_next[T_RETX]  = sat_dur(retx_dur);
                    pend_next[T_RETX] = 1'b1;
                end
            end
            REQ_SESSION:
            begin
                if (cfg.peer_valid)
                begin
                    rem_next[T_ZERO]  = sat_dur(zero_dur);
                    pend_next[T_ZERO] = 1'b1;
                end
            end
            default: ;  // unknown request: no change
        endcase

        res.attempt_count = att_next;
        res.pending_mask  = pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
                rem_reg[i] <= '0;
            pend_reg <= '0;
            att_reg  <= '0;
            nka_reg  <= 1'b0;
        end
        else if (fire)
        begin
            rem_reg  <= rem_next;
            pend_reg <= pend_next;
            att_reg  <= att_next;
            nka_reg  <= nka_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tunnel_peer_timer_engine_unit.sv
// ----------------------------------------------------------------------------
// tunnel_peer_timer_engine_unit: timer engine of one secure-tunnel peer
// Five one-shot ms timers plus handshake attempt tracking, one result word
// per request word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: req_type
//   (tick or event code) and jitter_ms. Every request yields exactly one
//   result word on the output channel (out_valid / out_stall).
//   A word is taken when valid is high and stall is low at a rising edge.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes one
//   register per word; cfg_ready is always high. Write only while idle.
// Path: each request passes the input register, then the result register.
// Throughput: one word per cycle while out_stall is low. The timer update is a
//   single pass from the input register to the state and result registers, so
//   a tick right after an event sees that event's effect.
// Stall: the input register acts as a skid stage. While the result register
//   is held by out_stall, one more request is taken and parked; in_stall
//   then rises until the result drains.
// Reset: rst_n (async, active low) clears all timers, the attempt count and
//   both pipeline valids, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tunnel_peer_timer_engine_unit
    import tpte_pkg::*;
#(
    parameter int TIMER_WIDTH = 22
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [REQ_W-1:0]      req_type,
    input  wire logic [JIT_W-1:0]      jitter_ms,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       start_handshake,
    output logic                       handshake_retry,
    output logic [1:0]                 keepalive_sends,
    output logic                       purge_queue,
    output logic                       zero_keys,
    output logic [ATT_W-1:0]           attempt_count,
    output logic [NUM_TIMERS-1:0]      pending_mask,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg;
    result_t          res;

    // input (skid) register
    logic             in_valid_reg, in_valid_next;
    logic [REQ_W-1:0] req_reg;
    logic [JIT_W-1:0] jit_reg;

    // result register
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg;

    logic             advance;   // result register can take a new word
    logic             fire;      // parked request is processed this cycle
    logic             in_take;

    assign cfg_ready = 1'b1;

    tpte_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tpte_timer_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .req    (req_reg),
        .jitter (jit_reg),
        .cfg    (cfg),
        .res    (res)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg <= req_type;
            jit_reg <= jitter_ms;
        end
        if (fire)
            res_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign start_handshake = res_reg.start_handshake;
    assign handshake_retry = res_reg.handshake_retry;
    assign keepalive_sends = res_reg.keepalive_sends;
    assign purge_queue     = res_reg.purge_queue;
    assign zero_keys       = res_reg.zero_keys;
    assign attempt_count   = res_reg.attempt_count;
    assign pending_mask    = res_reg.pending_mask;

endmodule

`default_nettype wire

// File: rtl/tpte_checker.sv
// ----------------------------------------------------------------------------
// tpte_checker: port-level checks of the timer engine
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tpte_checker
    import tpte_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic                  start_handshake,
    input wire logic                  handshake_retry,
    input wire logic [1:0]            keepalive_sends,
    input wire logic                  purge_queue,
    input wire logic [ATT_W-1:0]      attempt_count,
    input wire logic [NUM_TIMERS-1:0] pending_mask
);

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(attempt_count)
            && $stable(pending_mask))
        else $error("stalled result word changed");

    // input backpressure only comes from a blocked result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in_stall without blocked output");

    // a retry is always a handshake request
    a_retry_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && handshake_retry |-> start_handshake)
        else $error("retry flag without start_handshake");

    // give-up and retry are exclusive outcomes of a retransmit expiry
    a_purge_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && purge_queue |-> !handshake_retry && keepalive_sends != 2'd3)
        else $error("purge together with retry");

endmodule

bind tunnel_peer_timer_engine_unit tpte_checker u_tpte_checker (.*);

`default_nettype wire

// File: sim/tunnel_peer_timer_engine_unit_test.sv
// ----------------------------------------------------------------------------
// tunnel_peer_timer_engine_unit_test: testbench of the peer timer engine
// Drives request words and register writes into the engine, mirrors the five
// peer timers, the attempt count and the keepalive flag in a scoreboard class,
// and checks every result word field by field against that mirror.
// ----------------------------------------------------------------------------

module tunnel_peer_timer_engine_unit_test;

    import tpte_pkg::*;

    localparam int TW = 22;

    // Request codes with no meaning and register slots with no register.
    localparam logic [REQ_W-1:0]     REQ_UNUSED_LO = REQ_SESSION + 1'b1;
    localparam logic [REQ_W-1:0]     REQ_UNUSED_HI = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_MAX_ATTEMPT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the timers and registers. take_request works out
    // the result word of an accepted request, match_result checks the oldest.
    // ------------------------------------------------------------------------
    class peer_timer_mirror;
        cfg_t            regs;
        logic [TW-1:0]   remain [NUM_TIMERS];
        bit              pend [NUM_TIMERS];
        logic [ATT_W-1:0] attempts;
        bit              need_ka;
        result_t         action_queue [$];
        int              mismatches;
        int              compared;
        int              n_starts;
        int              n_sends;
        int              n_purges;
        int              n_wipes;

        function new();
            regs = CFG_RESET;
            foreach (remain[i])
            begin
                remain[i] = '0;
                pend[i]   = 1'b0;
            end
            attempts = '0;
            need_ka  = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PEER_VALID:  regs.peer_valid        = data[0];
                CFG_PERSISTENT:  regs.persistent_enable = data[0];
                CFG_KEEPALIVE:   regs.keepalive_seconds = data[7:0];
                CFG_REKEY:       regs.rekey_seconds     = data[7:0];
                CFG_REJECT:      regs.reject_seconds    = data[9:0];
                CFG_MAX_ATTEMPT: regs.max_attempts      = data[5:0];
                default: ;
            endcase
        endfunction

        // Load a timer; zero becomes 1 ms, too long saturates.
        function void arm(int t, longint unsigned dur);
            longint unsigned top;
            top = (64'd1 << TW) - 1;
            if (!regs.peer_valid)
                return;
            if (dur == 0)
                dur = 1;
            if (dur > top)
                dur = top;
            remain[t] = dur[TW-1:0];
            pend[t]   = 1'b1;
        endfunction

        function void disarm(int t);
            remain[t] = '0;
            pend[t]   = 1'b0;
        endfunction

        function longint unsigned keepalive_ms();
            return longint'(regs.keepalive_seconds) * MS_PER_S;
        endfunction

        function longint unsigned wipe_ms();
            return longint'(regs.reject_seconds) * ZERO_FACTOR * MS_PER_S;
        endfunction

        function void take_request(logic [REQ_W-1:0] req, logic [JIT_W-1:0] jit_in);
            longint unsigned jit;
            result_t         r;
            bit              fired [NUM_TIMERS];
            jit = jit_in;
            if (jit > JITTER_MAX)
                jit = JITTER_MAX;
            r = '0;
            case (req)
                REQ_TICK:
                begin
                    // count everything down first, then run handlers in order
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        fired[i] = 1'b0;
                        if (pend[i])
                        begin
                            if (remain[i] != 0)
                                remain[i]--;
                            if (remain[i] == 0)
                            begin
                                pend[i]  = 1'b0;
                                fired[i] = 1'b1;
                            end
                        end
                    end
                    if (fired[T_RETX])
                    begin
                        if (attempts > regs.max_attempts)
                        begin
                            disarm(T_KA);
                            fired[T_KA]   = 1'b0;
                            r.purge_queue = 1'b1;
                            if (!pend[T_ZERO])
                                arm(T_ZERO, wipe_ms());
                        end
                        else
                        begin
                            if (attempts < ATT_MAX)
                                attempts++;
                            r.start_handshake = 1'b1;
                            r.handshake_retry = 1'b1;
                        end
                    end
                    if (fired[T_KA])
                    begin
                        r.keepalive_sends++;
                        if (need_ka)
                        begin
                            need_ka = 1'b0;
                            arm(T_KA, keepalive_ms());
                        end
                    end
                    if (fired[T_PERS] && regs.persistent_enable)
                        r.keepalive_sends++;
                    if (fired[T_ZERO])
                        r.zero_keys = 1'b1;
                    if (fired[T_NEWHS])
                        r.start_handshake = 1'b1;
                end
                REQ_DATA_RX:
                    if (!pend[T_KA])
                        arm(T_KA, keepalive_ms());
                    else
                        need_ka = 1'b1;
                REQ_DATA_TX:
                    if (!pend[T_NEWHS])
                        arm(T_NEWHS, (longint'(regs.keepalive_seconds) + regs.rekey_seconds)
                                     * MS_PER_S + jit);
                REQ_AUTH_TX:   disarm(T_KA);
                REQ_AUTH_RX:   disarm(T_NEWHS);
                REQ_AUTH_TRAV:
                    if (regs.persistent_enable)
                        arm(T_PERS, keepalive_ms());
                REQ_HS_DONE:
                begin
                    disarm(T_RETX);
                    attempts = '0;
                end
                REQ_HS_INIT:   arm(T_RETX, longint'(regs.rekey_seconds) * MS_PER_S + jit);
                REQ_SESSION:   arm(T_ZERO, wipe_ms());
                default: ;
            endcase
            r.attempt_count = attempts;
            for (int i = 0; i < NUM_TIMERS; i++)
                r.pending_mask[i] = pend[i];
            n_starts += r.start_handshake;
            n_sends  += r.keepalive_sends;
            n_purges += r.purge_queue;
            n_wipes  += r.zero_keys;
            action_queue.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] seen);
            if (seen !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
                mismatches++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (action_queue.size() == 0)
            begin
                $display("%0t: result word with nothing expected, expected none, got %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = action_queue.pop_front();
            compared++;
            check_field("start_handshake", want.start_handshake, got.start_handshake);
            check_field("handshake_retry", want.handshake_retry, got.handshake_retry);
            check_field("keepalive_sends", want.keepalive_sends, got.keepalive_sends);
            check_field("purge_queue",     want.purge_queue,     got.purge_queue);
            check_field("zero_keys",       want.zero_keys,       got.zero_keys);
            check_field("attempt_count",   want.attempt_count,   got.attempt_count);
            check_field("pending_mask",    want.pending_mask,    got.pending_mask);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its stimulus signals, all known from time zero
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [REQ_W-1:0]      req_type  = '0;
    logic [JIT_W-1:0]      jitter_ms = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  start_handshake;
    logic                  handshake_retry;
    logic [1:0]            keepalive_sends;
    logic                  purge_queue;
    logic                  zero_keys;
    logic [ATT_W-1:0]      attempt_count;
    logic [NUM_TIMERS-1:0] pending_mask;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    tunnel_peer_timer_engine_unit #(.TIMER_WIDTH(TW)) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .jitter_ms       (jitter_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .start_handshake (start_handshake),
        .handshake_retry (handshake_retry),
        .keepalive_sends (keepalive_sends),
        .purge_queue     (purge_queue),
        .zero_keys       (zero_keys),
        .attempt_count   (attempt_count),
        .pending_mask    (pending_mask),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    peer_timer_mirror mirror = new();

    bit idle_on    = 1'b1;   // random gaps and stalls; cleared for the last phase
    int sent_words = 0;
    int settings   = 0;

    always #5 clk = ~clk;

    // Single reset pulse at the start of the run.
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the block's
    // registers update, so the handshake view matches what the block saw.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                mirror.write_reg(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                mirror.match_result(result_t'({start_handshake, handshake_retry,
                                               keepalive_sends, purge_queue, zero_keys,
                                               attempt_count, pending_mask}));
            if (in_valid && !in_stall)
                mirror.take_request(req_type, jitter_ms);
        end
    end

    // Result-side back-pressure: bursts of stall, each followed by a free run
    // with stall low, so stall never drops and rises in one step.
    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. All are entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // One request word. Valid stays up across back-to-back words; a gap drops
    // it first and raises it again at a later falling edge.
    task automatic send_request(logic [REQ_W-1:0] req, logic [JIT_W-1:0] jit);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        jitter_ms <= jit;
        do
            @(posedge clk);
        while (in_stall);
        sent_words++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Full register set. Bits above each register's width carry junk, and the
    // two empty slots get written too; both must be ignored.
    task automatic program_regs(bit pv, bit pers, bit [7:0] ka, bit [7:0] rk,
                                bit [9:0] rj, bit [5:0] tries);
        write_reg(CFG_PEER_VALID,  {9'($urandom), pv});
        write_reg(CFG_PERSISTENT,  {9'($urandom), pers});
        write_reg(CFG_KEEPALIVE,   {2'($urandom), ka});
        write_reg(CFG_REKEY,       {2'($urandom), rk});
        write_reg(CFG_REJECT,      rj);
        write_reg(CFG_MAX_ATTEMPT, {4'($urandom), tries});
        write_reg(CFG_UNUSED_LO,   CFG_DATA_W'($urandom));
        write_reg(CFG_UNUSED_HI,   CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Let every expected word come out, then let the pipeline settle before
    // registers change.
    task automatic drain();
        in_valid <= 1'b0;
        while (mirror.action_queue.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------------
    typedef struct {
        bit       peer_on;
        bit       persist_on;
        bit [7:0] ka_s;
        bit [7:0] rekey_s;
        bit [9:0] reject_s;
        bit [5:0] tries;
        int       words;
        int       tick_pct;
        int       init_pct;
        int       jit_hi;
        bit       gaps;
    } phase_t;

    // Directed opener, run with every timeout at zero so each duration
    // collapses to 1 ms (or to the jitter) and expiries come at once.
    localparam int DRILL_LEN = 23;
    logic [REQ_W-1:0] drill_req [DRILL_LEN] = '{
        REQ_HS_INIT, REQ_DATA_RX, REQ_DATA_RX, REQ_TICK,     // retry plus keepalive re-arm
        REQ_HS_INIT, REQ_SESSION, REQ_TICK,                  // give-up: purge, ka dropped, wipe
        REQ_AUTH_TRAV, REQ_DATA_TX, REQ_TICK,                // persistent send, saturated jitter
        REQ_AUTH_RX, REQ_DATA_TX, REQ_TICK,                  // new handshake from 0 ms load
        REQ_DATA_RX, REQ_AUTH_TRAV, REQ_TICK,                // two keepalives in one tick
        REQ_DATA_RX, REQ_AUTH_TX, REQ_HS_INIT, REQ_HS_DONE,  // clears and attempt reset
        REQ_UNUSED_LO, REQ_UNUSED_HI, REQ_TICK
    };
    logic [JIT_W-1:0] drill_jit [DRILL_LEN] = '{
        9'd0, 9'd0, 9'd0, 9'd0,
        9'd0, 9'd0, 9'd0,
        9'd0, 9'd511, 9'd0,
        9'd0, 9'd0, 9'd0,
        9'd0, 9'd0, 9'd0,
        9'd0, 9'd0, 9'd511, 9'd0,
        9'd256, 9'd255, 9'd0
    };

    initial
    begin : stimulus
        phase_t           plan [7];
        int               pick;
        logic [REQ_W-1:0] req;
        logic [JIT_W-1:0] jit;

        //           pv pers  ka   rk   rj    max words tick init jit gaps
        plan[0] = '{1, 1,    0,   0,   0,    0,  100,  55,  10, 20,  1};  // instant give-up
        plan[1] = '{1, 0,    0,   0,   0,    2,  150,  55,  10, 20,  1};  // no persistent
        plan[2] = '{0, 1,    0,   0,   0,    0,   40,  50,  10, 20,  1};  // peer gone: no arming
        plan[3] = '{1, 1,    0,   0,   0,    5,  150,  65,  20,  2,  1};  // retry chains
        plan[4] = '{1, 1,  255, 255, 1023,  63,   40,  50,  10, 511, 1};  // longest timeouts
        plan[5] = '{1, 1,    1,   1,   1,    1, 1050,  99,   0, 20,  1};  // real 1 s expiries
        plan[6] = '{1, 1,    0,   0,   0,    1,  100,  55,  10, 20,  0};  // full rate

        wait (rst_n === 1'b1);
        @(negedge clk);

        // First words go out with reset defaults: peer not valid, nothing arms.
        send_request(REQ_DATA_RX, '0);
        send_request(REQ_HS_INIT, '1);
        send_request(REQ_TICK, '0);
        drain();

        program_regs(1'b1, 1'b1, '0, '0, '0, '0);
        for (int k = 0; k < DRILL_LEN; k++)
            send_request(drill_req[k], drill_jit[k]);

        foreach (plan[p])
        begin
            drain();
            idle_on = plan[p].gaps;
            program_regs(plan[p].peer_on, plan[p].persist_on, plan[p].ka_s,
                         plan[p].rekey_s, plan[p].reject_s, plan[p].tries);
            for (int k = 0; k < plan[p].words; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < plan[p].tick_pct)
                    req = REQ_TICK;
                else if (pick < plan[p].tick_pct + plan[p].init_pct)
                    req = REQ_HS_INIT;
                else if (pick < 97)
                    req = REQ_W'($urandom_range(REQ_DATA_RX, REQ_SESSION));
                else
                    req = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                // mostly short jitter so rekey timers fire, now and then the full field
                if ($urandom_range(0, 3) == 0)
                    jit = JIT_W'($urandom);
                else
                    jit = JIT_W'($urandom_range(0, plan[p].jit_hi));
                send_request(req, jit);
            end
        end

        drain();
        repeat (8) @(negedge clk);

        $display("Sent %0d request words under %0d register settings, %0d results compared.",
                 sent_words, settings, mirror.compared);
        $display("Expiries seen: %0d handshake requests, %0d keepalives, %0d purges, %0d wipes.",
                 mirror.n_starts, mirror.n_sends, mirror.n_purges, mirror.n_wipes);
        if (mirror.action_queue.size() != 0)
            $display("%0t: %0d result words never arrived, expected 0 left, got %0d",
                     $time, mirror.action_queue.size(), mirror.action_queue.size());
        if (mirror.mismatches == 0 && mirror.action_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
